>>> rtl/ehqt_pkg.sv
package ehqt_pkg;

    localparam int NODES_DEFAULT = 16;

    localparam int IDX_W     = 4;
    localparam int FAIL_W    = 8;
    localparam int HEALTH_W  = 5;
    localparam int TIME_W    = 32;
    localparam int QSEC_W    = 17;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [HEALTH_W-1:0] HEALTH_FULL    = 5'd20;
    localparam logic [HEALTH_W-1:0] HEALTH_GAIN    = 5'd4;
    localparam logic [HEALTH_W-1:0] HEALTH_LOSS    = 5'd5;
    localparam logic [HEALTH_W-1:0] HEALTH_LOW     = 5'd3;
    localparam logic [HEALTH_W-1:0] HEALTH_RELEASE = 5'd2;

    localparam logic [FAIL_W-1:0] FAIL_MAX         = 8'd255;
    localparam logic [FAIL_W-1:0] MAX_FAIL_RESET   = 8'd5;
    localparam logic [QSEC_W-1:0] QUAR_MIN         = 17'd30;
    localparam logic [QSEC_W-1:0] QUAR_SEC_RESET   = 17'd300;
    localparam logic [COUNT_W-1:0] COUNT_SAT       = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAR_SECONDS = 2'd1;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_SUCCESS = 2'd1,
        ACT_FAILURE = 2'd2,
        ACT_REFRESH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_WALK,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic                active;
        logic [FAIL_W-1:0]   failures;
        logic [HEALTH_W-1:0] health;
        logic [TIME_W-1:0]   qend;
    } t_entry;

    typedef struct packed {
        logic                status;
        logic                entry_active;
        logic                entry_quarantined;
        logic [FAIL_W-1:0]   fail_count;
        logic [HEALTH_W-1:0] health;
        logic [TIME_W-1:0]   release_time;
        logic [COUNT_W-1:0]  active_count;
        logic [COUNT_W-1:0]  quarantined_count;
    } t_result;

endpackage

>>> rtl/ehqt_if.sv
interface ehqt_req_if import ehqt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [IDX_W-1:0]  node_index;
    logic [TIME_W-1:0] now;

    modport source (output valid, output action, output node_index, output now, input ready);
    modport sink   (input valid, input action, input node_index, input now, output ready);
endinterface

interface ehqt_rsp_if import ehqt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic                entry_active;
    logic                entry_quarantined;
    logic [FAIL_W-1:0]   fail_count;
    logic [HEALTH_W-1:0] health;
    logic [TIME_W-1:0]   release_time;
    logic [COUNT_W-1:0]  active_count;
    logic [COUNT_W-1:0]  quarantined_count;

    modport source (
        output valid, output status, output entry_active, output entry_quarantined,
        output fail_count, output health, output release_time,
        output active_count, output quarantined_count, input ready
    );
    modport sink (
        input valid, input status, input entry_active, input entry_quarantined,
        input fail_count, input health, input release_time,
        input active_count, input quarantined_count, output ready
    );
endinterface

interface ehqt_cfg_if import ehqt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [QSEC_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ehqt_update.sv
module ehqt_update import ehqt_pkg::*; (
    input  t_action           i_action,
    input  logic [TIME_W-1:0] i_now,
    input  logic [FAIL_W-1:0] i_max_failures,
    input  logic [QSEC_W-1:0] i_quar_len,
    input  t_entry            i_entry,
    output t_entry            o_entry,
    output logic              o_quarantined
);

    always_comb begin
        t_entry            e;
        logic [HEALTH_W:0] h_up;
        logic [TIME_W:0]   end_sum;

        e       = i_entry;
        h_up    = {1'b0, i_entry.health} + {1'b0, HEALTH_GAIN};
        end_sum = {1'b0, i_now} + (TIME_W+1)'(i_quar_len);

        unique case (i_action)
            ACT_ADD: begin
                e.active   = 1'b1;
                e.failures = '0;
                e.health   = HEALTH_FULL;
                e.qend     = '0;
            end
            ACT_SUCCESS: begin
                e.active   = 1'b1;
                e.failures = '0;
                e.qend     = '0;
                e.health   = (h_up > {1'b0, HEALTH_FULL}) ? HEALTH_FULL : h_up[HEALTH_W-1:0];
            end
            ACT_FAILURE: begin
                if (i_entry.failures != FAIL_MAX) begin
                    e.failures = i_entry.failures + FAIL_W'(1);
                end
                e.health = (i_entry.health >= HEALTH_LOSS) ? i_entry.health - HEALTH_LOSS : '0;
                if (e.failures >= i_max_failures || e.health < HEALTH_LOW) begin
                    e.qend   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
                    e.active = 1'b0;
                end
            end
            ACT_REFRESH: begin
                // expired quarantine: release with one failure forgiven
                if (i_entry.qend != '0 && i_now >= i_entry.qend) begin
                    e.qend   = '0;
                    e.active = 1'b1;
                    if (i_entry.failures != '0) begin
                        e.failures = i_entry.failures - FAIL_W'(1);
                    end
                    if (i_entry.health < HEALTH_RELEASE) begin
                        e.health = HEALTH_RELEASE;
                    end
                end
                if (e.qend > i_now) begin
                    e.active = 1'b0;
                end else if (e.qend == '0) begin
                    e.active = 1'b1;
                end
            end
        endcase

        o_entry       = e;
        o_quarantined = e.qend > i_now;
    end

endmodule

>>> rtl/endpoint_health_quarantine_table_top.sv
// channel   | dir | handshake     | payload
// ----------+-----+---------------+----------------------------------------------
// i_cfg     | in  | valid / ready | index, data (max_failures, quarantine_seconds)
// i_req     | in  | valid / ready | action, node_index, now
// o_rsp     | out | valid / ready | status, entry fields, active / quarantined counts
//
// Add, success and failure pass through accept, entry RAM read and update, and
// output push. Refresh walks the table with the single RAM read port, one entry
// per cycle, with write-back of the previous entry.
// Reset clears the present bits at once; no clearing pass over the RAM.
// A stalled output holds the next result in the push state; config is always ready.
module endpoint_health_quarantine_table_top import ehqt_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ehqt_cfg_if.sink    i_cfg,
    ehqt_req_if.sink    i_req,
    ehqt_rsp_if.source  o_rsp
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    t_state            r_state, n_state;
    logic [FAIL_W-1:0] r_max_failures;
    logic [QSEC_W-1:0] r_quar_sec;
    logic [QSEC_W-1:0] c_quar_len;

    t_action           r_action;
    logic [AW-1:0]     r_addr;
    logic              r_idx_ok;
    logic [TIME_W-1:0] r_now;

    logic [NODES-1:0]  r_present, n_present;
    logic [AW-1:0]     r_walk, n_walk;
    logic [CW-1:0]     r_act_cnt, n_act_cnt;
    logic [CW-1:0]     r_quar_cnt, n_quar_cnt;
    t_result           r_pend, n_pend;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_entry            mem [NODES];
    t_entry            r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    t_entry            wr_data;

    logic [AW-1:0]     cur_addr;
    t_entry            upd_entry;
    logic              upd_quar;
    logic              req_accept;
    logic              cfg_accept;

    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;
    assign c_quar_len  = (r_quar_sec < QUAR_MIN) ? QUAR_MIN : r_quar_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_failures <= MAX_FAIL_RESET;
            r_quar_sec     <= QUAR_SEC_RESET;
        end else if (cfg_accept) begin
            if (i_cfg.index == CFG_MAX_FAILURES) begin
                r_max_failures <= i_cfg.data[FAIL_W-1:0];
            end else if (i_cfg.index == CFG_QUAR_SECONDS) begin
                r_quar_sec <= i_cfg.data;
            end
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    assign cur_addr    = (r_state == ST_WALK) ? r_walk : r_addr;

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_action <= t_action'(i_req.action);
            r_addr   <= AW'(i_req.node_index);
            r_idx_ok <= 32'(i_req.node_index) < NODES;
            r_now    <= i_req.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    ehqt_update u_update (
        .i_action       (r_action),
        .i_now          (r_now),
        .i_max_failures (r_max_failures),
        .i_quar_len     (c_quar_len),
        .i_entry        (r_rd_data),
        .o_entry        (upd_entry),
        .o_quarantined  (upd_quar)
    );

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_act_cnt   = r_act_cnt;
        n_quar_cnt  = r_quar_cnt;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_present   = r_present;
        mem_we      = 1'b0;
        wr_addr     = cur_addr;
        wr_data     = upd_entry;
        rd_addr     = r_walk + AW'(1);

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = (t_action'(i_req.action) == ACT_REFRESH) ? '0
                                                                   : AW'(i_req.node_index);
                if (req_accept) begin
                    n_walk     = '0;
                    n_act_cnt  = '0;
                    n_quar_cnt = '0;
                    n_state    = (t_action'(i_req.action) == ACT_REFRESH) ? ST_WALK
                                                                          : ST_ENTRY;
                end
            end
            ST_ENTRY: begin
                n_pend = '0;
                if (!r_idx_ok || (r_action != ACT_ADD && !r_present[r_addr])) begin
                    n_pend.status = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    if (r_action == ACT_ADD) begin
                        n_present[r_addr] = 1'b1;
                    end
                    n_pend.entry_active      = upd_entry.active;
                    n_pend.entry_quarantined = upd_quar;
                    n_pend.fail_count        = upd_entry.failures;
                    n_pend.health            = upd_entry.health;
                    n_pend.release_time      = upd_entry.qend;
                end
                n_state = ST_PUSH;
            end
            ST_WALK: begin
                if (r_present[r_walk]) begin
                    mem_we = 1'b1;
                    if (upd_quar) begin
                        n_quar_cnt = r_quar_cnt + CW'(1);
                    end else if (upd_entry.active) begin
                        n_act_cnt = r_act_cnt + CW'(1);
                    end
                end
                if (r_walk == LAST) begin
                    n_pend = '0;
                    n_pend.active_count      = (32'(n_act_cnt) > 32'(COUNT_SAT))
                                             ? COUNT_SAT : COUNT_W'(n_act_cnt);
                    n_pend.quarantined_count = (32'(n_quar_cnt) > 32'(COUNT_SAT))
                                             ? COUNT_SAT : COUNT_W'(n_quar_cnt);
                    n_state = ST_PUSH;
                end else begin
                    n_walk = r_walk + AW'(1);
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk     <= n_walk;
        r_act_cnt  <= n_act_cnt;
        r_quar_cnt <= n_quar_cnt;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.entry_active      = r_out.entry_active;
    assign o_rsp.entry_quarantined = r_out.entry_quarantined;
    assign o_rsp.fail_count        = r_out.fail_count;
    assign o_rsp.health            = r_out.health;
    assign o_rsp.release_time      = r_out.release_time;
    assign o_rsp.active_count      = r_out.active_count;
    assign o_rsp.quarantined_count = r_out.quarantined_count;

`ifndef NO_ASSERTIONS
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_walk != LAST)
        |=> (r_state == ST_WALK && r_walk == $past(r_walk) + AW'(1)))
        else $error("refresh walk skipped or stopped early");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> (r_state != ST_IDLE && !i_req.ready))
        else $error("request accepted while still idle");

    a_rise_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_PUSH)
        else $error("result valid raised outside push");

    a_health_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> wr_data.health <= HEALTH_FULL)
        else $error("health written above full");

    a_counts_refresh_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.active_count != '0 || o_rsp.quarantined_count != '0))
        |-> (!o_rsp.status && o_rsp.fail_count == '0 && o_rsp.release_time == '0))
        else $error("counts mixed with entry fields");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ehqt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    ehqt_cfg_if cfg_if ();
    ehqt_req_if req_if ();
    ehqt_rsp_if rsp_if ();

    endpoint_health_quarantine_table_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted table contents and settings
    bit                  node_present [NODES_DEFAULT];
    bit                  node_active  [NODES_DEFAULT];
    logic [FAIL_W-1:0]   node_fails   [NODES_DEFAULT];
    logic [HEALTH_W-1:0] node_health  [NODES_DEFAULT];
    logic [TIME_W-1:0]   node_qend    [NODES_DEFAULT];
    logic [FAIL_W-1:0]   fail_limit;
    logic [QSEC_W-1:0]   quar_len_cfg;

    t_result           results_due[$];
    int                mismatches;
    bit                idling_on;
    bit                quiet_tail;
    logic [TIME_W-1:0] clock_base;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("** endpoint_health_quarantine_table_top: FAILED **");
        $finish;
    end

    function automatic t_result table_step(t_action act, logic [IDX_W-1:0] idx,
                                           logic [TIME_W-1:0] t);
        t_result           r;
        int                n_act;
        int                n_quar;
        int                h;
        logic [QSEC_W-1:0] len;
        logic [TIME_W:0]   sum;
        r = '0;
        n_act = 0;
        n_quar = 0;
        if (act == ACT_REFRESH) begin
            for (int i = 0; i < NODES_DEFAULT; i++) begin
                if (!node_present[i]) continue;
                if (node_qend[i] != '0 && t >= node_qend[i]) begin
                    node_qend[i] = '0;
                    node_active[i] = 1'b1;
                    if (node_fails[i] != '0) node_fails[i] = node_fails[i] - FAIL_W'(1);
                    if (node_health[i] < HEALTH_RELEASE) node_health[i] = HEALTH_RELEASE;
                end
                if (node_qend[i] > t) node_active[i] = 1'b0;
                else if (node_qend[i] == '0) node_active[i] = 1'b1;
                if (node_qend[i] > t) n_quar++;
                else if (node_active[i]) n_act++;
            end
            r.active_count = COUNT_W'(n_act);
            r.quarantined_count = COUNT_W'(n_quar);
            return r;
        end
        if (act == ACT_ADD) begin
            node_present[idx] = 1'b1;
            node_active[idx] = 1'b1;
            node_fails[idx] = '0;
            node_health[idx] = HEALTH_FULL;
            node_qend[idx] = '0;
        end else if (!node_present[idx]) begin
            r.status = 1'b1;
            return r;
        end else if (act == ACT_SUCCESS) begin
            h = int'(node_health[idx]) + int'(HEALTH_GAIN);
            node_fails[idx] = '0;
            node_qend[idx] = '0;
            node_active[idx] = 1'b1;
            node_health[idx] = (h > int'(HEALTH_FULL)) ? HEALTH_FULL : HEALTH_W'(h);
        end else begin
            len = (quar_len_cfg < QUAR_MIN) ? QUAR_MIN : quar_len_cfg;
            if (node_fails[idx] != FAIL_MAX) node_fails[idx] = node_fails[idx] + FAIL_W'(1);
            node_health[idx] = (node_health[idx] >= HEALTH_LOSS)
                               ? node_health[idx] - HEALTH_LOSS : '0;
            if (node_fails[idx] >= fail_limit || node_health[idx] < HEALTH_LOW) begin
                sum = {1'b0, t} + (TIME_W + 1)'(len);
                node_qend[idx] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                node_active[idx] = 1'b0;
            end
        end
        r.entry_active = node_active[idx];
        r.entry_quarantined = node_qend[idx] > t;
        r.fail_count = node_fails[idx];
        r.health = node_health[idx];
        r.release_time = node_qend[idx];
        return r;
    endfunction

    task automatic send_req(t_action act, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.action = act;
        req_if.node_index = idx;
        req_if.now = t;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        results_due.insert(results_due.size(), table_step(act, idx, t));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (results_due.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [QSEC_W-1:0] value);
        drain_results();
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data = value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        if (index == CFG_MAX_FAILURES) fail_limit = value[FAIL_W-1:0];
        else if (index == CFG_QUAR_SECONDS) quar_len_cfg = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_now(int step_max);
        if ($urandom_range(0, 99) < 4) return $urandom();
        clock_base = clock_base + $urandom_range(0, step_max);
        return clock_base;
    endfunction

    task automatic run_mix(int count, int step_max, int drain_at);
        int                r;
        t_action           act;
        logic [IDX_W-1:0]  idx;
        for (int n = 0; n < count; n++) begin
            if (n == drain_at) drain_results();
            if (!quiet_tail && $urandom_range(0, 79) == 0) idling_on = ~idling_on;
            r = $urandom_range(0, 99);
            if (r < 8) act = ACT_ADD;
            else if (r < 33) act = ACT_SUCCESS;
            else if (r < 80) act = ACT_FAILURE;
            else act = ACT_REFRESH;
            idx = IDX_W'($urandom_range(0, $urandom_range(0, 1) ? 15 : 5));
            send_req(act, idx, next_now(step_max));
        end
    endtask

    task automatic test_basic_ops();
        send_req(ACT_REFRESH, 4'd9, 32'd0);
        send_req(ACT_SUCCESS, 4'd3, 32'd5);
        send_req(ACT_FAILURE, 4'd15, 32'd5);
        send_req(ACT_ADD, 4'd0, 32'd10);
        send_req(ACT_ADD, 4'd15, 32'hFFFF_FFFF);
        send_req(ACT_SUCCESS, 4'd0, 32'd11);
        repeat (4) send_req(ACT_FAILURE, 4'd0, 32'd100);
        send_req(ACT_FAILURE, 4'd0, 32'd120);
        send_req(ACT_REFRESH, 4'd0, 32'd200);
        send_req(ACT_REFRESH, 4'd0, 32'd420);
        send_req(ACT_ADD, 4'd5, 32'd421);
        // quarantine end past the top of the time range
        repeat (4) send_req(ACT_FAILURE, 4'd15, 32'hFFFF_FF00);
        send_req(ACT_REFRESH, 4'd15, 32'hFFFF_FFFE);
        send_req(ACT_SUCCESS, 4'd15, 32'd0);
        send_req(ACT_ADD, 4'd0, 32'd500);
        send_req(ACT_REFRESH, 4'd6, 32'h8000_0000);
        send_req(ACT_FAILURE, 4'd5, 32'h5555_5555);
        send_req(ACT_SUCCESS, 4'd5, 32'hAAAA_AAAA);
    endtask

    task automatic test_short_quarantine();
        write_reg(CFG_MAX_FAILURES, 17'd1);
        write_reg(CFG_QUAR_SECONDS, 17'd0);
        clock_base = 32'd1000;
        run_mix(250, 12, -1);
    endtask

    task automatic test_fail_saturation();
        write_reg(CFG_MAX_FAILURES, 17'd255);
        write_reg(CFG_QUAR_SECONDS, 17'd29);
        send_req(ACT_ADD, 4'd7, clock_base);
        repeat (260) send_req(ACT_FAILURE, 4'd7, next_now(20));
        send_req(ACT_REFRESH, 4'd7, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_threshold();
        // upper data bits are ignored for the failure threshold, leaving zero
        write_reg(CFG_MAX_FAILURES, 17'h1FF00);
        write_reg(CFG_SPARE, 17'h1FFFF);
        write_reg(CFG_QUAR_SECONDS, 17'd30);
        run_mix(250, 15, -1);
    endtask

    task automatic test_long_quarantine();
        write_reg(CFG_MAX_FAILURES, 17'd3);
        write_reg(CFG_QUAR_SECONDS, 17'h1FFFF);
        run_mix(250, 3000, 125);
    endtask

    task automatic test_time_wrap();
        write_reg(CFG_MAX_FAILURES, 17'($urandom_range(1, 255)));
        write_reg(CFG_QUAR_SECONDS, 17'd86400);
        clock_base = 32'hFFFF_0000;
        run_mix(250, 700, -1);
    endtask

    task automatic test_random_settings();
        logic [QSEC_W-1:0] len;
        for (int p = 0; p < 3; p++) begin
            len = QSEC_W'($urandom_range(0, 131071));
            if (p == 0) len = 17'($urandom_range(0, 400));
            write_reg(CFG_MAX_FAILURES, 17'($urandom_range(0, 255)));
            write_reg(CFG_QUAR_SECONDS, len);
            run_mix(200, int'(len) / 8 + 10, -1);
        end
    endtask

    task automatic test_steady_stream();
        write_reg(CFG_MAX_FAILURES, 17'(MAX_FAIL_RESET));
        write_reg(CFG_QUAR_SECONDS, 17'(QUAR_SEC_RESET));
        quiet_tail = 1'b1;
        idling_on = 1'b0;
        run_mix(250, 40, -1);
    endtask

    task automatic flag_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk) begin : rsp_check
        t_result want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no request outstanding");
            end else begin
                want = results_due.pop_front();
                flag_field("status", TIME_W'(want.status), TIME_W'(rsp_if.status));
                flag_field("entry_active", TIME_W'(want.entry_active),
                           TIME_W'(rsp_if.entry_active));
                flag_field("entry_quarantined", TIME_W'(want.entry_quarantined),
                           TIME_W'(rsp_if.entry_quarantined));
                flag_field("fail_count", TIME_W'(want.fail_count),
                           TIME_W'(rsp_if.fail_count));
                flag_field("health", TIME_W'(want.health), TIME_W'(rsp_if.health));
                flag_field("release_time", want.release_time, rsp_if.release_time);
                flag_field("active_count", TIME_W'(want.active_count),
                           TIME_W'(rsp_if.active_count));
                flag_field("quarantined_count", TIME_W'(want.quarantined_count),
                           TIME_W'(rsp_if.quarantined_count));
            end
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        req_if.valid = 1'b0;
        req_if.action = ACT_ADD;
        req_if.node_index = '0;
        req_if.now = '0;
        mismatches = 0;
        idling_on = 1'b1;
        quiet_tail = 1'b0;
        clock_base = '0;
        fail_limit = MAX_FAIL_RESET;
        quar_len_cfg = QUAR_SEC_RESET;
        for (int i = 0; i < NODES_DEFAULT; i++) begin
            node_present[i] = 1'b0;
            node_active[i] = 1'b0;
            node_fails[i] = '0;
            node_health[i] = '0;
            node_qend[i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_short_quarantine();
        test_fail_saturation();
        test_zero_threshold();
        test_long_quarantine();
        test_time_wrap();
        test_random_settings();
        test_steady_stream();

        drain_results();
        repeat (NODES_DEFAULT + 8) @(negedge clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("** endpoint_health_quarantine_table_top: PASSED **");
        end else begin
            $display("** endpoint_health_quarantine_table_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> endpoint_health_quarantine_table_top.f
rtl/ehqt_pkg.sv
rtl/ehqt_if.sv
rtl/ehqt_update.sv
rtl/endpoint_health_quarantine_table_top.sv
verif/tb_top.sv
